// ----- hdl/pmlt_pkg.sv -----
// ----------------------------------------------------------------------------
// pmlt_pkg
// Types and constants shared by the paged MMU tracker modules.
// ----------------------------------------------------------------------------
package pmlt_pkg;

  localparam int OffsetWidth = 12;
  localparam int FrameCount  = 16;
  localparam int TablePages  = 1024;
  localparam int RegionSlots = 8;

  localparam int FrameW  = $clog2(FrameCount);
  localparam int PageW   = $clog2(TablePages);
  localparam int RegW    = $clog2(RegionSlots);
  localparam int RcntW   = $clog2(FrameCount + 1);
  localparam int RgcntW  = $clog2(RegionSlots + 1);

  typedef enum logic [2:0] {
    OP_READ   = 3'd0,
    OP_WRITE  = 3'd1,
    OP_MAP    = 3'd2,
    OP_ALLOC  = 3'd3,
    OP_FREE   = 3'd4,
    OP_VICTIM = 3'd5,
    OP_REGION = 3'd6,
    OP_NONE   = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BOUNDS   = 3'd1,
    ST_FAULT    = 3'd2,
    ST_NOFREE   = 3'd3,
    ST_RANGE    = 3'd4,
    ST_NOEVICT  = 3'd5,
    ST_FULL     = 3'd6,
    ST_RSVD     = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    CFG_CODE_BASE  = 3'd0,
    CFG_CODE_SIZE  = 3'd1,
    CFG_DATA_BASE  = 3'd2,
    CFG_DATA_SIZE  = 3'd3,
    CFG_HEAP_START = 3'd4,
    CFG_HEAP_END   = 3'd5,
    CFG_STACK_TOP  = 3'd6,
    CFG_STACK_MAX  = 3'd7
  } cfg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_SWEEP,
    S_FINISH,
    S_OUT
  } state_e;

  // command to the recency chain, applied on each chain step
  typedef struct packed {
    logic              remove;   // cell holding key drops out
    logic              touch;    // key moves to the front
    logic [FrameW-1:0] key;
  } rec_cmd_t;

endpackage

// ----- hdl/pmlt_rec_cell.sv -----
// ----------------------------------------------------------------------------
// pmlt_rec_cell
// One slot of the recency order: holds a frame number and a valid flag and
// shifts toward the back or closes a gap as the command asks.
// ----------------------------------------------------------------------------
module pmlt_rec_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_i,
  input  pmlt_pkg::rec_cmd_t       cmd_i,
  input  logic                     prev_hit_i,
  input  logic                     prev_vld_i,
  input  logic [pmlt_pkg::FrameW-1:0] prev_frame_i,
  input  logic                     next_vld_i,
  input  logic [pmlt_pkg::FrameW-1:0] next_frame_i,
  input  logic                     is_head_i,
  output logic                     vld_o,
  output logic [pmlt_pkg::FrameW-1:0] frame_o,
  output logic                     hit_o
);

  logic                        vld_q, vld_d;
  logic [pmlt_pkg::FrameW-1:0] frame_q, frame_d;
  logic                        self_hit;

  assign self_hit = vld_q && (frame_q == cmd_i.key);
  // hit_o: this cell or any ahead of it matches the key
  assign hit_o    = self_hit || prev_hit_i;

  always_comb begin
    vld_d   = vld_q;
    frame_d = frame_q;
    if (cmd_i.touch) begin
      if (is_head_i) begin
        vld_d   = 1'b1;
        frame_d = cmd_i.key;
      end else if (!prev_hit_i) begin
        vld_d   = prev_vld_i || vld_q;
        frame_d = prev_vld_i ? prev_frame_i : frame_q;
        if (!prev_vld_i) begin
          vld_d = vld_q;
        end
      end
    end else if (cmd_i.remove) begin
      if (hit_o) begin
        vld_d   = next_vld_i;
        frame_d = next_frame_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (step_i) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      frame_q <= frame_d;
    end
  end

  assign vld_o   = vld_q;
  assign frame_o = frame_q;

endmodule

// ----- hdl/pmlt_rec_chain.sv -----
// ----------------------------------------------------------------------------
// pmlt_rec_chain
// Row of recency cells, most recent at slot 0. Valid cells form a prefix.
// ----------------------------------------------------------------------------
module pmlt_rec_chain (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  pmlt_pkg::rec_cmd_t         cmd_i,
  output logic [pmlt_pkg::FrameCount-1:0] vld_o,
  output logic [pmlt_pkg::FrameCount-1:0][pmlt_pkg::FrameW-1:0] frame_o
);

  localparam int N = pmlt_pkg::FrameCount;

  logic [N-1:0] hit;

  for (genvar c = 0; c < N; c++) begin : g_cell
    logic                        pv, ph, nv;
    logic [pmlt_pkg::FrameW-1:0] pf, nf;
    if (c == 0) begin : g_head
      assign pv = 1'b0;
      assign ph = 1'b0;
      assign pf = '0;
    end else begin : g_body
      assign pv = vld_o[c-1];
      assign ph = hit[c-1];
      assign pf = frame_o[c-1];
    end
    if (c == N - 1) begin : g_tail
      assign nv = 1'b0;
      assign nf = '0;
    end else begin : g_mid
      assign nv = vld_o[c+1];
      assign nf = frame_o[c+1];
    end
    pmlt_rec_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .step_i      (step_i),
      .cmd_i       (cmd_i),
      .prev_hit_i  (ph),
      .prev_vld_i  (pv),
      .prev_frame_i(pf),
      .next_vld_i  (nv),
      .next_frame_i(nf),
      .is_head_i   (c == 0),
      .vld_o       (vld_o[c]),
      .frame_o     (frame_o[c]),
      .hit_o       (hit[c])
    );
  end

`ifndef SYNTHESIS
  a_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((vld_o >> 1) & ~vld_o) == '0)
    else $error("recency valid bits not a prefix");
  a_head_after_touch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && cmd_i.touch |=> vld_o[0] && frame_o[0] == $past(cmd_i.key))
    else $error("touched frame not at front");
  a_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(vld_o[0] && vld_o[1] && frame_o[0] == frame_o[1]))
    else $error("duplicate frame at front");
`endif

endmodule

// ----- hdl/paged_mmu_lru_tracker_top.sv -----
// ----------------------------------------------------------------------------
// paged_mmu_lru_tracker_top
// Paged MMU: page table, frame used map, recency chain and region table.
//
// channel | direction | handshake          | payload
// cfg     | in        | cfg_valid/cfg_ready | cfg_index_i, cfg_data_i
// in      | in        | in_valid/in_ready   | opcode .. pinned_mask
// out     | out       | out_valid/out_ready | status .. virt_base
//
// One item at a time: accept, table read in S_LOOKUP, region sweep in
// S_SWEEP, chain update in S_FINISH, result in S_OUT. Victim search
// replaces the sweep and scans the chain from the back, one slot per
// cycle. Reset clears the valid/dirty page table one entry at a time;
// no item is accepted meanwhile. A stalled result holds the block.
// ----------------------------------------------------------------------------
module paged_mmu_lru_tracker_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  opcode_i,
  input  logic [31:0] vaddr_i,
  input  logic [9:0]  virt_page_i,
  input  logic [3:0]  phys_page_in_i,
  input  logic [31:0] region_size_i,
  input  logic [15:0] pinned_mask_i,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status_o,
  output logic [15:0] phys_addr_o,
  output logic [3:0]  phys_page_out_o,
  output logic [19:0] fault_page_o,
  output logic [31:0] virt_base_o
);

  localparam int NF  = pmlt_pkg::FrameCount;
  localparam int FW  = pmlt_pkg::FrameW;
  localparam int PW  = pmlt_pkg::PageW;
  localparam int OW  = pmlt_pkg::OffsetWidth;
  localparam int NR  = pmlt_pkg::RegionSlots;
  localparam int CW  = $clog2(NF + NR + 1) + 1;

  pmlt_pkg::state_e state_q, state_d;

  logic [31:0] cfg_q [8];
  logic [NF-1:0] used_q, used_d;
  logic [31:0] rstart_q [NR];
  logic [31:0] rlen_q [NR];
  logic [pmlt_pkg::RgcntW-1:0] rcnt_q, rcnt_d;

  // page table memory: bit 0 valid, bit 1 dirty, rest frame
  logic [FW+1:0] pt_mem [pmlt_pkg::TablePages];
  logic [FW+1:0] pt_rd_q;
  logic          pt_we;
  logic [PW-1:0] pt_wa;
  logic [FW+1:0] pt_wd;
  logic [PW:0]   clr_q;
  logic          clr_busy;

  logic [2:0]  op_q;
  logic [31:0] va_q, rs_q;
  logic [9:0]  vp_q;
  logic [3:0]  pp_q;
  logic [15:0] pin_q;
  logic        inb_q, inb_d;
  logic [CW-1:0] cnt_q, cnt_d;

  logic [2:0]  st_q, st_d;
  logic [15:0] pa_q, pa_d;
  logic [3:0]  po_q, po_d;
  logic [19:0] fp_q, fp_d;
  logic [31:0] vb_q, vb_d;

  pmlt_pkg::rec_cmd_t cmd;
  logic               step;
  logic [NF-1:0]      rvld;
  logic [NF-1:0][FW-1:0] rfrm;

  logic in_acc;
  logic [19:0] page;
  logic [FW-1:0] free_idx;
  logic          free_any;
  logic [FW-1:0] scan_idx;
  logic [FW-1:0] sf;

  assign clr_busy  = !clr_q[PW];
  assign cfg_ready = 1'b1;
  assign in_ready  = (state_q == pmlt_pkg::S_IDLE) && !clr_busy;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = (state_q == pmlt_pkg::S_OUT);
  assign page      = va_q[31:OW];

  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = NF - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_idx = FW'(i);
        free_any = 1'b1;
      end
    end
  end

  assign scan_idx = FW'(cnt_q - 1'b1);
  assign sf       = rfrm[scan_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (clr_busy) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pt_we) begin
      pt_mem[pt_wa] <= pt_wd;
    end
    pt_rd_q <= pt_mem[page[PW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= opcode_i;
      va_q  <= vaddr_i;
      vp_q  <= virt_page_i;
      pp_q  <= phys_page_in_i;
      rs_q  <= region_size_i;
      pin_q <= pinned_mask_i;
    end
    if (state_q == pmlt_pkg::S_FINISH && op_q == pmlt_pkg::OP_REGION &&
        rcnt_q < pmlt_pkg::RgcntW'(NR)) begin
      rstart_q[rcnt_q[pmlt_pkg::RegW-1:0]] <= va_q;
      rlen_q[rcnt_q[pmlt_pkg::RegW-1:0]]   <= rs_q;
    end
    inb_q <= inb_d;
    cnt_q <= cnt_d;
    st_q  <= st_d;
    pa_q  <= pa_d;
    po_q  <= po_d;
    fp_q  <= fp_d;
    vb_q  <= vb_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pmlt_pkg::S_IDLE;
      used_q  <= '0;
      rcnt_q  <= '0;
      cfg_q   <= '{default: '0};
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      rcnt_q  <= rcnt_d;
      if (cfg_valid && cfg_ready) begin
        cfg_q[cfg_index_i] <= cfg_data_i;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      pmlt_pkg::S_IDLE:   if (in_acc) state_d = pmlt_pkg::S_LOOKUP;
      pmlt_pkg::S_LOOKUP: state_d = pmlt_pkg::S_SWEEP;
      pmlt_pkg::S_SWEEP: begin
        if (op_q == pmlt_pkg::OP_VICTIM) begin
          if (cnt_q == '0 || (rvld[scan_idx] && !(pin_q[sf]))) begin
            state_d = pmlt_pkg::S_FINISH;
          end
        end else if (cnt_q == CW'(NR)) begin
          state_d = pmlt_pkg::S_FINISH;
        end
      end
      pmlt_pkg::S_FINISH: state_d = pmlt_pkg::S_OUT;
      pmlt_pkg::S_OUT:    if (out_ready) state_d = pmlt_pkg::S_IDLE;
      default:            state_d = pmlt_pkg::S_IDLE;
    endcase
  end

  function automatic logic [FW:0] rcnt_chain(input logic [NF-1:0] v);
    logic [FW:0] n;
    n = '0;
    for (int i = 0; i < NF; i++) begin
      if (v[i]) n = (FW+1)'(i + 1);
    end
    return n;
  endfunction

  always_comb begin
    logic [31:0] cb_e, db_e, sb_e, re;
    logic        hit;
    cb_e = cfg_q[pmlt_pkg::CFG_CODE_BASE] + cfg_q[pmlt_pkg::CFG_CODE_SIZE];
    db_e = cfg_q[pmlt_pkg::CFG_DATA_BASE] + cfg_q[pmlt_pkg::CFG_DATA_SIZE];
    sb_e = cfg_q[pmlt_pkg::CFG_STACK_TOP] - cfg_q[pmlt_pkg::CFG_STACK_MAX];
    re   = rstart_q[cnt_q[pmlt_pkg::RegW-1:0]] + rlen_q[cnt_q[pmlt_pkg::RegW-1:0]];
    hit  = 1'b0;
    inb_d = inb_q;
    cnt_d = cnt_q;
    st_d = st_q; pa_d = pa_q; po_d = po_q; fp_d = fp_q; vb_d = vb_q;
    used_d = used_q;
    rcnt_d = rcnt_q;
    pt_we = 1'b0;
    pt_wa = page[PW-1:0];
    pt_wd = pt_rd_q;
    cmd   = '{remove: 1'b0, touch: 1'b0, key: '0};
    step  = 1'b0;
    if (clr_busy) begin
      pt_we = 1'b1;
      pt_wa = clr_q[PW-1:0];
      pt_wd = '0;
    end
    case (state_q)
      pmlt_pkg::S_LOOKUP: begin
        hit = (va_q >= cfg_q[pmlt_pkg::CFG_CODE_BASE] && va_q < cb_e) ||
              (va_q >= cfg_q[pmlt_pkg::CFG_DATA_BASE] && va_q < db_e) ||
              (va_q >= cfg_q[pmlt_pkg::CFG_HEAP_START] &&
               va_q < cfg_q[pmlt_pkg::CFG_HEAP_END]) ||
              (va_q < cfg_q[pmlt_pkg::CFG_STACK_TOP] && va_q >= sb_e);
        inb_d = hit;
        cnt_d = (op_q == pmlt_pkg::OP_VICTIM) ? CW'(rcnt_chain(rvld)) : '0;
        st_d = pmlt_pkg::ST_OK; pa_d = '0; po_d = '0; fp_d = '0; vb_d = '0;
      end
      pmlt_pkg::S_SWEEP: begin
        if (op_q == pmlt_pkg::OP_VICTIM) begin
          if (cnt_q != '0 && rvld[scan_idx] && !pin_q[sf]) begin
            po_d = sf;
          end else if (cnt_q == '0) begin
            st_d = pmlt_pkg::ST_NOEVICT;
          end else begin
            cnt_d = cnt_q - 1'b1;
          end
        end else if (cnt_q != CW'(NR)) begin
          if (CW'(rcnt_q) > cnt_q && va_q >= rstart_q[cnt_q[pmlt_pkg::RegW-1:0]] &&
              va_q < re) begin
            inb_d = 1'b1;
          end
          cnt_d = cnt_q + 1'b1;
        end
      end
      pmlt_pkg::S_FINISH: begin
        case (op_q)
          pmlt_pkg::OP_READ, pmlt_pkg::OP_WRITE: begin
            if (!inb_q) begin
              st_d = pmlt_pkg::ST_BOUNDS;
            end else if (page >= 20'(pmlt_pkg::TablePages) || !pt_rd_q[0]) begin
              st_d = pmlt_pkg::ST_FAULT;
              fp_d = page;
            end else begin
              if (op_q == pmlt_pkg::OP_WRITE) begin
                pt_we = 1'b1;
                pt_wd = {pt_rd_q[FW+1:2], 2'b11};
              end
              step = 1'b1;
              cmd  = '{remove: 1'b0, touch: 1'b1, key: pt_rd_q[FW+1:2]};
              pa_d = 16'(({12'd0, pt_rd_q[FW+1:2]} << OW) + {4'd0, va_q[OW-1:0]});
            end
          end
          pmlt_pkg::OP_MAP: begin
            pt_we = 1'b1;
            pt_wa = vp_q[PW-1:0];
            pt_wd = {pp_q, 2'b01};
            vb_d  = 32'(vp_q) << OW;
          end
          pmlt_pkg::OP_ALLOC: begin
            if (!free_any) begin
              st_d = pmlt_pkg::ST_NOFREE;
            end else begin
              used_d[free_idx] = 1'b1;
              step = 1'b1;
              cmd  = '{remove: 1'b0, touch: 1'b1, key: free_idx};
              po_d = free_idx;
            end
          end
          pmlt_pkg::OP_FREE: begin
            used_d[pp_q] = 1'b0;
            step = 1'b1;
            cmd  = '{remove: 1'b1, touch: 1'b0, key: pp_q};
          end
          pmlt_pkg::OP_REGION: begin
            if (rcnt_q >= pmlt_pkg::RgcntW'(NR)) begin
              st_d = pmlt_pkg::ST_FULL;
            end else begin
              rcnt_d = rcnt_q + 1'b1;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  pmlt_rec_chain u_chain (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(step),
    .cmd_i (cmd),
    .vld_o (rvld),
    .frame_o(rfrm)
  );

  assign status_o        = st_q;
  assign phys_addr_o     = pa_q;
  assign phys_page_out_o = po_q;
  assign fault_page_o    = fp_q;
  assign virt_base_o     = vb_q;

`ifndef SYNTHESIS
  a_no_accept_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> !in_ready)
    else $error("item accepted during table clear");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(status_o))
    else $error("result dropped");
  a_rcnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rcnt_q <= pmlt_pkg::RgcntW'(NR))
    else $error("region count overflow");
`endif

endmodule
